// File: src/kpsef_pkg.sv
// ----------------------------------------------------------------------------
// kpsef_pkg
// Shared types and constants of the keypad scanner with its event queue.
// ----------------------------------------------------------------------------
package kpsef_pkg;

	// Event queue geometry. The queue holds at most QUEUE_DEPTH - 1 events.
	localparam int QUEUE_DEPTH = 32;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Operation codes carried in the func field of an input word.
	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SAMPLE = 2'd1,
		FUNC_POP    = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	// One queued key event.
	typedef struct packed {
		logic       press;
		logic [7:0] code;
	} event_t;

	// Request from the scanner to the queue.
	typedef struct packed {
		logic   push;
		event_t push_data;
		logic   pop;
	} q_req_t;

	// Queue status; fill_nxt is the count after this cycle's push or pop.
	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QPTR_W-1:0] fill_nxt;
	} q_stat_t;

	// Character of each key; key index is column * 4 + row position.
	localparam logic [7:0] KEYMAP [16] = '{
		8'h44, 8'h43, 8'h42, 8'h41, 8'h23, 8'h39, 8'h36, 8'h33,
		8'h30, 8'h38, 8'h35, 8'h32, 8'h2A, 8'h37, 8'h34, 8'h31
	};

endpackage

// File: src/kpsef_req_if.sv
// ----------------------------------------------------------------------------
// kpsef_req_if
// Input channel of the keypad scanner: operation code and sampled rows.
// ----------------------------------------------------------------------------
interface kpsef_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] row_bits;

	modport source (output valid, output func, output row_bits, input ready);
	modport sink   (input valid, input func, input row_bits, output ready);
endinterface

// File: src/kpsef_rsp_if.sv
// ----------------------------------------------------------------------------
// kpsef_rsp_if
// Result channel of the keypad scanner: column drive, popped event, fill.
// ----------------------------------------------------------------------------
interface kpsef_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_drive;
	logic       pop_valid;
	logic       key_pressed;
	logic [7:0] key_code;
	logic [4:0] queue_fill;

	modport source (output valid, output column_drive, output pop_valid,
		output key_pressed, output key_code, output queue_fill, input ready);
	modport sink   (input valid, input column_drive, input pop_valid,
		input key_pressed, input key_code, input queue_fill, output ready);
endinterface

// File: src/kpsef_queue.sv
// ----------------------------------------------------------------------------
// kpsef_queue
// Ring queue of key events in a synchronous memory with registered read.
// ----------------------------------------------------------------------------
module kpsef_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kpsef_pkg::q_req_t         req,
	output kpsef_pkg::q_stat_t        stat,
	output kpsef_pkg::event_t         rd_data
);

	localparam int PW = kpsef_pkg::QPTR_W;
	localparam logic [PW-1:0] LAST_IDX = PW'(kpsef_pkg::QUEUE_DEPTH - 1);
	localparam logic [PW:0]   DEPTH_V  = (PW+1)'(kpsef_pkg::QUEUE_DEPTH);

	kpsef_pkg::event_t mem_q [kpsef_pkg::QUEUE_DEPTH];
	kpsef_pkg::event_t rd_data_q;
	logic [PW-1:0] wp_q, rp_q;
	logic [PW-1:0] wp_adv, rp_adv, wp_nxt, rp_nxt;
	logic [PW:0]   fill_wide;
	logic          do_push, do_pop;

	assign wp_adv = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign rp_adv = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;

	assign stat.empty = (wp_q == rp_q);
	assign stat.full  = (wp_adv == rp_q);

	// A push into a full queue is dropped; a pop of an empty queue does nothing.
	assign do_push = req.push && !stat.full;
	assign do_pop  = req.pop && !stat.empty;

	assign wp_nxt = do_push ? wp_adv : wp_q;
	assign rp_nxt = do_pop  ? rp_adv : rp_q;

	always_comb begin
		if (wp_nxt >= rp_nxt) begin
			fill_wide = {1'b0, wp_nxt} - {1'b0, rp_nxt};
		end else begin
			fill_wide = DEPTH_V - {1'b0, rp_nxt} + {1'b0, wp_nxt};
		end
	end
	assign stat.fill_nxt = fill_wide[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_nxt;
			rp_q <= rp_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= req.push_data;
		end
	end

	// The read word holds until the next pop, so a stalled result keeps it.
	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_data_q <= mem_q[rp_q];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/keypad_scanner_event_fifo_top.sv
// ----------------------------------------------------------------------------
// keypad_scanner_event_fifo_top
// 4x4 keypad matrix scanner that queues press and release events.
// ----------------------------------------------------------------------------
// Each input word is a column tick, a row sample, a pop request or a no-op,
// and gives exactly one result word through the execute, read and output
// stages in order. Ticks, pops, no-ops and samples taken before the first
// tick stream at one word per cycle while the result side takes words. A
// row sample works through its four row bits one at a time, since every
// changed key writes its event through the single write port of the event
// memory. Events beyond the capacity of the queue (QUEUE_DEPTH - 1) are
// dropped, while the key state still follows the rows. Output and middle
// stages let the input side keep working while a result waits to be taken.
module keypad_scanner_event_fifo_top (
	input  logic          clk,
	input  logic          arst_n,
	kpsef_req_if.sink     req,
	kpsef_rsp_if.source   rsp
);

	// Scan state.
	logic [1:0]  col_q;
	logic        started_q;
	logic [15:0] held_q;

	// Execute stage.
	logic              valid_s1;
	kpsef_pkg::func_t  func_s1;
	logic [3:0]        rows_s1;
	logic [1:0]        bit_q;

	// Stage waiting for the memory read.
	logic        valid_s2;
	logic [3:0]  drive_s2;
	logic        pop_s2;
	logic [4:0]  fill_s2;

	// Output register.
	logic        out_valid_q;
	logic [3:0]  out_drive_q;
	logic        out_pop_q;
	logic        out_press_q;
	logic [7:0]  out_code_q;
	logic [4:0]  out_fill_q;

	kpsef_pkg::q_req_t  q_req;
	kpsef_pkg::q_stat_t q_stat;
	kpsef_pkg::event_t  q_rd;

	logic        out_free, s2_move, s2_free;
	logic        samp_active, last_s1, move_s1, bit_go, changed, key_on;
	logic        tick_go, started_nxt;
	logic [1:0]  col_nxt;
	logic [3:0]  key_idx;

	assign out_free = !out_valid_q || rsp.ready;
	assign s2_move  = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_move;

	assign samp_active = valid_s1 && (func_s1 == kpsef_pkg::FUNC_SAMPLE) && started_q;
	assign last_s1     = valid_s1 && (!samp_active || bit_q == 2'd3);
	assign move_s1     = last_s1 && s2_free;
	// The last row bit is worked only when the word can leave the stage.
	assign bit_go      = samp_active && ((bit_q != 2'd3) || s2_free);

	assign req.ready = !valid_s1 || move_s1;

	// Row bit b of column c is key c*4 + (3 - b).
	assign key_idx = {col_q, ~bit_q};
	assign key_on  = rows_s1[bit_q];
	assign changed = bit_go && (key_on != held_q[key_idx]);

	assign q_req.push           = changed;
	assign q_req.push_data.press = key_on;
	assign q_req.push_data.code  = kpsef_pkg::KEYMAP[key_idx];
	assign q_req.pop            = move_s1 && (func_s1 == kpsef_pkg::FUNC_POP);

	assign tick_go     = move_s1 && (func_s1 == kpsef_pkg::FUNC_TICK);
	assign started_nxt = started_q || tick_go;
	assign col_nxt     = (tick_go && started_q) ? col_q + 2'd1 : col_q;

	kpsef_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (q_req),
		.stat    (q_stat),
		.rd_data (q_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			started_q <= 1'b0;
			held_q    <= '0;
		end else begin
			col_q     <= col_nxt;
			started_q <= started_nxt;
			if (changed) begin
				held_q[key_idx] <= key_on;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			bit_q    <= '0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
				bit_q    <= '0;
			end else begin
				if (move_s1) begin
					valid_s1 <= 1'b0;
				end
				if (bit_go) begin
					bit_q <= bit_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= kpsef_pkg::func_t'(req.func);
			rows_s1 <= req.row_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			drive_s2 <= started_nxt ? (4'b0001 << col_nxt) : 4'b0000;
			pop_s2   <= q_req.pop && !q_stat.empty;
			fill_s2  <= 5'(q_stat.fill_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_drive_q <= drive_s2;
			out_pop_q   <= pop_s2;
			out_press_q <= pop_s2 && q_rd.press;
			out_code_q  <= pop_s2 ? q_rd.code : 8'h00;
			out_fill_q  <= fill_s2;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.column_drive = out_drive_q;
	assign rsp.pop_valid    = out_pop_q;
	assign rsp.key_pressed  = out_press_q;
	assign rsp.key_code     = out_code_q;
	assign rsp.queue_fill   = out_fill_q;

`ifndef SYNTH
	// One word in execute means one memory access a cycle: never both.
	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_req.push && q_req.pop))
		else $error("queue push and pop in the same cycle");

	// The row bit counter is back at zero whenever the execute stage is empty.
	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (bit_q == 2'd0))
		else $error("row bit counter not cleared at end of sample");

	// A successful pop reaches the read stage flagged as valid.
	a_pop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(q_req.pop && !q_stat.empty) |=> (valid_s2 && pop_s2))
		else $error("popped event lost before read stage");
`endif

endmodule

// File: tb/sv/keypad_scanner_event_fifo_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_scanner_event_fifo_top_tb
// Self-checking bench for the keypad scanner and its key event queue.
// ----------------------------------------------------------------------------
// A clocked driver feeds column ticks, row samples, pops and no-ops from a
// pending list. A behavioral scanner in the bench predicts each result word
// when its input word is taken. A clocked monitor compares every result word
// field by field against the oldest prediction. Both sides insert random
// gaps, and at four points the driver holds off until the result side is empty.
// ----------------------------------------------------------------------------
module keypad_scanner_event_fifo_top_tb;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned PRINT_CAP = 40;
	// Key characters, key 0 first (in the top byte).
	localparam logic [8*16-1:0] KEY_CHARS = "DCBA#9630852*741";

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  rows;
		int unsigned gap_after;
		bit          drain;
	} scan_word_t;

	typedef struct {
		logic [3:0] column_drive;
		logic       pop_valid;
		logic       key_pressed;
		logic [7:0] key_code;
		logic [4:0] queue_fill;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kpsef_req_if req ();
	kpsef_rsp_if rsp ();

	keypad_scanner_event_fifo_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Scanner state as the bench sees it.
	logic [1:0]         scan_col = 2'd0;
	bit                 scanning = 1'b0;
	bit                 key_down [16];
	kpsef_pkg::event_t  ev_ring [kpsef_pkg::QUEUE_DEPTH];
	int unsigned        ev_wr = 0;
	int unsigned        ev_rd = 0;

	scan_word_t   word_q [$];
	scan_result_t scan_q [$];

	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned words_sent;
	int unsigned words_seen;
	int unsigned idle_cycles = 0;
	int unsigned cycle_cnt = 0;
	int unsigned err_count = 0;
	int unsigned n_queued = 0;
	int unsigned n_dropped = 0;
	int unsigned n_pop_hit = 0;
	int unsigned n_pop_empty = 0;
	int unsigned max_fill = 0;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_CAP) begin
			$display("%0t ns  result word %0d: %s", $time, words_seen, msg);
		end
	endtask

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic scan_result_t predict_scan(input logic [1:0] op,
			input logic [3:0] rows);
		scan_result_t      res;
		kpsef_pkg::event_t ev;
		int unsigned       k;
		int unsigned       nxt;
		int unsigned       fill;
		res = '{default: '0};
		case (kpsef_pkg::func_t'(op))
			kpsef_pkg::FUNC_TICK: begin
				// The first tick only starts the scan; column 0 stays selected.
				if (scanning) scan_col = scan_col + 2'd1;
				else scanning = 1'b1;
			end
			kpsef_pkg::FUNC_SAMPLE: begin
				if (scanning) begin
					for (int b = 0; b < 4; b++) begin
						k = scan_col * 4 + (3 - b);
						if (rows[b] != key_down[k]) begin
							key_down[k] = rows[b];
							ev.press = rows[b];
							ev.code = KEY_CHARS[8*(15-k) +: 8];
							nxt = (ev_wr + 1 == kpsef_pkg::QUEUE_DEPTH) ? 0 : ev_wr + 1;
							// One slot always stays free; a full queue loses the event.
							if (nxt == ev_rd) begin
								n_dropped++;
							end else begin
								ev_ring[ev_wr] = ev;
								ev_wr = nxt;
								n_queued++;
							end
						end
					end
				end
			end
			kpsef_pkg::FUNC_POP: begin
				if (ev_wr != ev_rd) begin
					ev = ev_ring[ev_rd];
					ev_rd = (ev_rd + 1 == kpsef_pkg::QUEUE_DEPTH) ? 0 : ev_rd + 1;
					res.pop_valid = 1'b1;
					res.key_pressed = ev.press;
					res.key_code = ev.code;
					n_pop_hit++;
				end else begin
					n_pop_empty++;
				end
			end
			default: begin
			end
		endcase
		fill = (ev_wr >= ev_rd) ? ev_wr - ev_rd : kpsef_pkg::QUEUE_DEPTH - ev_rd + ev_wr;
		if (fill > max_fill) max_fill = fill;
		res.column_drive = scanning ? (4'b0001 << scan_col) : 4'b0000;
		res.queue_fill = 5'(fill);
		return res;
	endfunction

	task automatic add_word(input logic [1:0] op, input logic [3:0] rows,
			input bit quiet, input bit drain);
		scan_word_t w;
		w.op = op;
		w.rows = rows;
		w.gap_after = pick_gap(quiet);
		w.drain = drain;
		word_q.push_back(w);
	endtask

	// Driver: presents pending words and predicts each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		scan_word_t nxt;
		logic       hs;
		logic       drained;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= kpsef_pkg::FUNC_TICK;
			req.row_bits <= 4'h0;
			gap_left <= 0;
			words_sent <= 0;
		end else begin
			hs = req.valid && req.ready;
			drained = (words_sent + hs == words_seen + (rsp.valid && rsp.ready));
			if (hs) begin
				scan_q.push_back(predict_scan(req.func, req.row_bits));
				words_sent <= words_sent + 1;
			end
			if (!req.valid || hs) begin
				if (gap_left != 0) begin
					req.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (word_q.size() != 0 && (!word_q[0].drain || drained)) begin
					nxt = word_q.pop_front();
					req.valid <= 1'b1;
					req.func <= nxt.op;
					req.row_bits <= nxt.rows;
					gap_left <= nxt.gap_after;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and the field by field compare.
	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		int unsigned  stall;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
			words_seen <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				words_seen <= words_seen + 1;
				if (scan_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = scan_q.pop_front();
					if (rsp.column_drive !== want.column_drive)
						report_mismatch($sformatf("column_drive %b, expected %b",
							rsp.column_drive, want.column_drive));
					if (rsp.pop_valid !== want.pop_valid)
						report_mismatch($sformatf("pop_valid %b, expected %b",
							rsp.pop_valid, want.pop_valid));
					if (rsp.key_pressed !== want.key_pressed)
						report_mismatch($sformatf("key_pressed %b, expected %b",
							rsp.key_pressed, want.key_pressed));
					if (rsp.key_code !== want.key_code)
						report_mismatch($sformatf("key_code %h, expected %h",
							rsp.key_code, want.key_code));
					if (rsp.queue_fill !== want.queue_fill)
						report_mismatch($sformatf("queue_fill %0d, expected %0d",
							rsp.queue_fill, want.queue_fill));
				end
			end
			if (stall_left != 0) begin
				rsp.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				// In a window that recurs with the cycle count, the result side runs without stalls.
				stall = pick_gap((cycle_cnt % 600) < 150);
				if (stall != 0) begin
					rsp.ready <= 1'b0;
					stall_left <= stall - 1;
				end else begin
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1;
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned pop_pct;
		int unsigned r;
		bit          quiet;
		logic [1:0]  op;
		logic [3:0]  rows;

		// Directed opening: a sample before the scan starts, an empty pop, a
		// no-op, the first tick, full press and release, column wrap, and
		// enough changes to overflow the queue.
		add_word(kpsef_pkg::FUNC_SAMPLE, 4'hF, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_POP,    4'h0, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_NOP,    4'hA, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_TICK,   4'h5, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_SAMPLE, 4'hF, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_SAMPLE, 4'h0, 1'b0, 1'b0);
		repeat (4) add_word(kpsef_pkg::FUNC_TICK, 4'h0, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			add_word(kpsef_pkg::FUNC_SAMPLE, (i % 2 == 0) ? 4'hF : 4'h0, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_NOP,    4'h5, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_POP,    4'hF, 1'b0, 1'b1);
		add_word(kpsef_pkg::FUNC_POP,    4'h0, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_TICK,   4'h0, 1'b0, 1'b0);
		add_word(kpsef_pkg::FUNC_SAMPLE, 4'hA, 1'b0, 1'b0);

		// Random part in segments; the pop share swings so that the queue
		// both fills up and runs dry.
		for (int seg = 0; seg < 20; seg++) begin
			case ($urandom_range(0, 2))
				0: pop_pct = 5;
				1: pop_pct = 25;
				default: pop_pct = 55;
			endcase
			quiet = (seg % 4 == 2);
			for (int n = 0; n < 60; n++) begin
				r = $urandom_range(0, 99);
				rows = 4'($urandom_range(0, 15));
				if (r < pop_pct) begin
					op = kpsef_pkg::FUNC_POP;
				end else if (r < pop_pct + 3) begin
					op = kpsef_pkg::FUNC_NOP;
				end else if (r < pop_pct + 3 + (100 - pop_pct) / 3) begin
					op = kpsef_pkg::FUNC_TICK;
				end else begin
					op = kpsef_pkg::FUNC_SAMPLE;
					case ($urandom_range(0, 9))
						0: rows = 4'h0;
						1: rows = 4'hF;
						default: begin
						end
					endcase
				end
				add_word(op, rows, quiet, n == 0 && seg % 6 == 3);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || req.valid || words_sent != words_seen)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (scan_q.size() != 0)
			report_mismatch($sformatf("%0d expected words never came", scan_q.size()));
		$display("Ran %0d words: %0d key events queued, %0d lost to a full queue, peak fill %0d.",
			words_sent, n_queued, n_dropped, max_fill);
		$display("Pops: %0d returned an event, %0d hit an empty queue; %0d errors.",
			n_pop_hit, n_pop_empty, err_count);
		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
src/kpsef_pkg.sv
src/kpsef_req_if.sv
src/kpsef_rsp_if.sv
src/kpsef_queue.sv
src/keypad_scanner_event_fifo_top.sv
tb/sv/keypad_scanner_event_fifo_top_tb.sv
